// ----- design/srfp_pkg.sv -----
// Shared types and constants of the servo response frame parser.
package srfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int OPCODE_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 4;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'd85;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [OPCODE_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_ARM  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_CSUM     = 2'd1,
    STAT_TIMEOUT  = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    arm;
    logic    tick;
    logic    store;
    logic    add_sum;
    logic    load_len;
    logic    emit_start;
    logic    rd_issue;
    logic    out_byte;
    logic    out_status;
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hdr_match;
    logic full;
    logic len_done;
    logic csum_ok;
    logic timed_out;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ----- design/srfp_item_if.sv -----
// Input request channel: opcode and received byte.
interface srfp_item_if import srfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

// ----- design/srfp_result_if.sv -----
// Result request channel: status, frame byte, position and run end.
interface srfp_result_if import srfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   frame_byte;
  logic [POS_W-1:0]    byte_position;
  logic                last;

  modport source (output valid, output status, output frame_byte, output byte_position,
                  output last, input ready);
  modport sink (input valid, input status, input frame_byte, input byte_position,
                input last, output ready);
endinterface

// ----- design/srfp_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface srfp_cfg_if import srfp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/servo_response_frame_parser_unit.sv -----
// Top level of the servo response frame parser.
// After an arm request the block parses one response frame from received bytes: two header
// bytes equal to the header register, then id, length, command, parameter bytes and an
// inverted-sum checksum; time ticks count toward the timeout register, and bytes or ticks
// while not armed are dropped. Arm, tick and byte requests are each taken whenever the
// result register is free. A good frame is then sent as a run of its stored bytes (header
// through checksum, last set on the final one): each byte takes a registered read of the
// frame store, then a load of the result register that waits while the result sink holds
// ready low; no request is taken during the run. A checksum error, a timeout or a frame
// longer than FRAME_MAX bytes each give one status result. Configuration writes are taken
// in any cycle; the user must send them only while the block is idle (not enforced).
module servo_response_frame_parser_unit import srfp_pkg::*; #(
  parameter int FRAME_MAX = 16
) (
  input  logic          clk,
  input  logic          rst,
  srfp_item_if.sink     item,
  srfp_result_if.source result,
  srfp_cfg_if.sink      cfg
);

  cmd_t cmd;
  sts_t sts;

  srfp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .sts  (sts),
    .cmd  (cmd)
  );

  srfp_dpath #(
    .FRAME_MAX (FRAME_MAX)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (item.rx_byte),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .result  (result)
  );

endmodule

// ----- design/srfp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module srfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/srfp_dpath.sv -----
// Datapath: config registers, counters, checksum, frame store and result register.
module srfp_dpath import srfp_pkg::*; #(
  parameter int FRAME_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  srfp_cfg_if.sink             cfg,
  srfp_result_if.source        result
);

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int IDX_W = $clog2(FRAME_MAX);
  localparam int CMP_W = BYTE_W + 1;

  logic [BYTE_W-1:0] header_value;
  logic [TICK_W-1:0] timeout_ticks;
  logic [CNT_W-1:0]  stored_count;
  logic [BYTE_W-1:0] declared_length;
  logic [BYTE_W-1:0] running_sum;
  logic [TICK_W-1:0] tick_count;
  logic [TICK_W-1:0] tick_next;
  logic [IDX_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  rd_idx_ext;
  logic [BYTE_W-1:0] rd_data;

  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;
  logic              out_last;

  // Configuration writes, always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value  <= HEADER_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HEADER:  header_value  <= cfg.data[BYTE_W-1:0];
        CFG_TIMEOUT: timeout_ticks <= cfg.data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating tick count and status toward the controller
  assign tick_next  = (tick_count == '1) ? tick_count : tick_count + TICK_W'(1);
  assign rd_idx_ext = CNT_W'(rd_idx);

  always_comb begin
    sts.hdr_match = (rx_byte == header_value);
    sts.full      = (stored_count >= CNT_W'(FRAME_MAX));
    sts.len_done  = (CMP_W'(stored_count) >= CMP_W'(declared_length) + CMP_W'(1));
    sts.csum_ok   = ((~running_sum) == rx_byte);
    sts.timed_out = (tick_next >= timeout_ticks);
    sts.emit_last = ((rd_idx_ext + CNT_W'(1)) == stored_count);
    sts.out_free  = !out_valid || result.ready;
  end

  // Frame counters, clear on arm
  always_ff @(posedge clk) begin
    if (rst || cmd.arm) begin
      stored_count    <= '0;
      declared_length <= '0;
      running_sum     <= '0;
      tick_count      <= '0;
    end else begin
      if (cmd.tick) begin
        tick_count <= tick_next;
      end
      if (cmd.store) begin
        stored_count <= stored_count + CNT_W'(1);
      end
      if (cmd.add_sum) begin
        running_sum <= running_sum + rx_byte;
      end
      if (cmd.load_len) begin
        declared_length <= rx_byte;
      end
    end
  end

  // Read pointer for emitting a good frame
  always_ff @(posedge clk) begin
    if (rst || cmd.emit_start) begin
      rd_idx <= '0;
    end else if (cmd.out_byte) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  srfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_MAX)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (stored_count[IDX_W-1:0]),
    .wr_data (rx_byte),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_byte || cmd.out_status) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_status) begin
      out_status <= cmd.status;
      out_byte   <= '0;
      out_pos    <= '0;
      out_last   <= 1'b1;
    end else if (cmd.out_byte) begin
      out_status <= STAT_OK;
      out_byte   <= rd_data;
      out_pos    <= rd_idx_ext[POS_W-1:0];
      out_last   <= sts.emit_last;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_status;
  assign result.frame_byte    = out_byte;
  assign result.byte_position = out_pos;
  assign result.last          = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(FRAME_MAX))
    else $error("stored byte count beyond store depth");

  a_read_in_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (rd_idx_ext < stored_count))
    else $error("store read beyond stored bytes");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(cmd.out_byte || cmd.out_status))
    else $error("pending result overwritten");
`endif

endmodule

// ----- design/srfp_ctrl.sv -----
// Controller: parse state machine and frame emission sequencing.
module srfp_ctrl import srfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  srfp_item_if.sink item,
  input  sts_t     sts,
  output cmd_t     cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_HEAD1     = 9'b000000010,
    S_HEAD2     = 9'b000000100,
    S_ID        = 9'b000001000,
    S_LEN       = 9'b000010000,
    S_CMD       = 9'b000100000,
    S_PARAM     = 9'b001000000,
    S_CSUM      = 9'b010000000,
    S_EMIT_RD   = 9'b100000000
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    emit_wait;
  logic    emit_wait_next;
  logic    emitting;
  logic    in_ready;
  logic    accept;
  opcode_t opcode;

  // Take requests only outside a frame run and with the result slot free
  assign emitting   = (state == S_EMIT_RD) || emit_wait;
  assign in_ready   = !emitting && sts.out_free;
  assign item.ready = in_ready;
  assign accept     = item.valid && in_ready;
  assign opcode     = opcode_t'(item.opcode);

  // Next state and commands
  always_comb begin
    cmd            = '0;
    state_next     = state;
    emit_wait_next = emit_wait;
    if (emit_wait) begin
      // Move the read byte into the result register
      if (sts.out_free) begin
        cmd.out_byte   = 1'b1;
        emit_wait_next = 1'b0;
        state_next     = sts.emit_last ? S_IDLE : S_EMIT_RD;
      end
    end else if (state == S_EMIT_RD) begin
      cmd.rd_issue   = 1'b1;
      emit_wait_next = 1'b1;
    end else if (accept) begin
      unique case (opcode)
        OP_ARM: begin
          cmd.arm    = 1'b1;
          state_next = S_HEAD1;
        end
        OP_TICK: begin
          if (state != S_IDLE) begin
            cmd.tick = 1'b1;
            if (sts.timed_out) begin
              cmd.out_status = 1'b1;
              cmd.status     = STAT_TIMEOUT;
              state_next     = S_IDLE;
            end
          end
        end
        OP_BYTE: begin
          if (state != S_IDLE &&
              !((state == S_HEAD1 || state == S_HEAD2) && !sts.hdr_match)) begin
            if (sts.full) begin
              cmd.out_status = 1'b1;
              cmd.status     = STAT_OVERFLOW;
              state_next     = S_IDLE;
            end else begin
              cmd.store = 1'b1;
              unique case (state)
                S_HEAD1: state_next = S_HEAD2;
                S_HEAD2: state_next = S_ID;
                S_ID: begin
                  cmd.add_sum = 1'b1;
                  state_next  = S_LEN;
                end
                S_LEN: begin
                  cmd.add_sum  = 1'b1;
                  cmd.load_len = 1'b1;
                  state_next   = S_CMD;
                end
                S_CMD: begin
                  cmd.add_sum = 1'b1;
                  state_next  = S_PARAM;
                end
                S_PARAM: begin
                  cmd.add_sum = 1'b1;
                  if (sts.len_done) begin
                    state_next = S_CSUM;
                  end
                end
                S_CSUM: begin
                  if (sts.csum_ok) begin
                    cmd.emit_start = 1'b1;
                    state_next     = S_EMIT_RD;
                  end else begin
                    cmd.out_status = 1'b1;
                    cmd.status     = STAT_CSUM;
                    state_next     = S_IDLE;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_wait <= 1'b0;
    end else begin
      state     <= state_next;
      emit_wait <= emit_wait_next;
    end
  end

`ifndef SYNTHESIS
  a_store_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !sts.full)
    else $error("byte stored into a full frame store");

  a_emit_after_good_sum: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_start |=> (state == S_EMIT_RD) && $past(sts.csum_ok))
    else $error("frame run started without a good checksum");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> emit_wait && !cmd.rd_issue)
    else $error("store read not followed by a result load wait");
`endif

endmodule

// ----- tb/servo_response_frame_parser_unit_tb.sv -----
// Testbench for the servo response frame parser: predictor, scoreboard and stimulus.
package srfp_tb_pkg;
  import srfp_pkg::*;

  localparam int STORE_DEPTH = 16;

  typedef enum logic [2:0] {
    P_IDLE, P_HEAD1, P_HEAD2, P_ID, P_LEN, P_CMD, P_PARAM, P_CSUM
  } parse_phase_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  position;
    logic              last;
  } frame_result_t;

  // Tracks the parser state and holds the results it must produce, oldest first
  class frame_scoreboard;
    logic [BYTE_W-1:0] header_reg;
    logic [TICK_W-1:0] timeout_reg;
    parse_phase_t      phase;
    int unsigned       stored;
    logic [BYTE_W-1:0] length_byte;
    logic [BYTE_W-1:0] running_sum;
    logic [TICK_W-1:0] ticks;
    logic [BYTE_W-1:0] store [STORE_DEPTH];
    frame_result_t     expected_q [$];
    int errors, requests, results, good_frames, csum_errors, timeouts, overflows;

    function new();
      header_reg  = HEADER_RESET;
      timeout_reg = TIMEOUT_RESET;
      phase       = P_IDLE;
      stored      = 0;
      length_byte = '0;
      running_sum = '0;
      ticks       = '0;
      foreach (store[k]) store[k] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_HEADER) begin
        header_reg = data[BYTE_W-1:0];
      end else if (idx == CFG_TIMEOUT) begin
        timeout_reg = data[TICK_W-1:0];
      end
    endfunction

    // End the frame with one status result and disarm
    function void end_frame(status_t st);
      phase = P_IDLE;
      expected_q.push_back('{status: st, frame_byte: '0, position: '0, last: 1'b1});
      case (st)
        STAT_CSUM:     csum_errors++;
        STAT_TIMEOUT:  timeouts++;
        STAT_OVERFLOW: overflows++;
        default: ;
      endcase
    endfunction

    // Advance the parser by one accepted request
    function void note_request(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] inverted;
      requests++;
      if (op == OP_ARM) begin
        phase       = P_HEAD1;
        stored      = 0;
        length_byte = '0;
        running_sum = '0;
        ticks       = '0;
        return;
      end
      if (op == OP_TICK) begin
        if (phase == P_IDLE) return;
        if (ticks != {TICK_W{1'b1}}) ticks++;
        if (ticks >= timeout_reg) end_frame(STAT_TIMEOUT);
        return;
      end
      if (op != OP_BYTE || phase == P_IDLE) return;
      // Drop a header byte that does not match, keep waiting for it
      if ((phase == P_HEAD1 || phase == P_HEAD2) && b != header_reg) return;
      if (stored >= STORE_DEPTH) begin
        end_frame(STAT_OVERFLOW);
        return;
      end
      store[stored] = b;
      stored++;
      case (phase)
        P_HEAD1: phase = P_HEAD2;
        P_HEAD2: phase = P_ID;
        P_ID: begin
          running_sum += b;
          phase = P_LEN;
        end
        P_LEN: begin
          running_sum += b;
          length_byte = b;
          phase = P_CMD;
        end
        P_CMD: begin
          running_sum += b;
          phase = P_PARAM;
        end
        P_PARAM: begin
          running_sum += b;
          if (stored - 2 >= length_byte) phase = P_CSUM;
        end
        default: begin
          inverted = ~running_sum;
          if (inverted != b) begin
            end_frame(STAT_CSUM);
          end else begin
            phase = P_IDLE;
            good_frames++;
            for (int k = 0; k < stored; k++) begin
              expected_q.push_back('{status: STAT_OK, frame_byte: store[k],
                                     position: POS_W'(k), last: (k + 1 == stored)});
            end
          end
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t ns: %s", $time, what);
      errors++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(frame_result_t got);
      frame_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d byte %02h pos %0d",
                                  got.status, got.frame_byte, got.position));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.frame_byte !== want.frame_byte)
        report_mismatch($sformatf("frame_byte %02h, want %02h at pos %0d",
                                  got.frame_byte, want.frame_byte, want.position));
      if (got.position !== want.position)
        report_mismatch($sformatf("byte_position %0d, want %0d", got.position, want.position));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b at pos %0d",
                                  got.last, want.last, want.position));
    endtask
  endclass
endpackage

module servo_response_frame_parser_unit_tb;
  import srfp_pkg::*;
  import srfp_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 400;

  typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_OVERFLOW, FRAME_CUT} frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  srfp_item_if   item_ch ();
  srfp_result_if result_ch ();
  srfp_cfg_if    cfg_ch ();

  servo_response_frame_parser_unit #(.FRAME_MAX(STORE_DEPTH)) DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  frame_scoreboard sb;
  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;
  int hold_request  = 0;
  int tick_pct      = 0;
  int stall_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Feed accepted requests to the predictor
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      sb.note_request(item_ch.opcode, item_ch.rx_byte);
  end

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready)
      sb.set_register(cfg_ch.index, cfg_ch.data);
  end

  // Check every accepted result
  always @(posedge clk) begin : result_monitor
    frame_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.status     = status_t'(result_ch.status);
      got.frame_byte = result_ch.frame_byte;
      got.position   = result_ch.byte_position;
      got.last       = result_ch.last;
      sb.check_result(got);
    end
  end

  // Drive result ready: random stalls, steady stretches, and a long hold on request
  initial begin : result_sink
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request after a random gap; hold valid high until it is taken
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] b);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.opcode  <= op;
    item_ch.rx_byte <= b;
    item_ch.valid   <= 1'b1;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Drop valid and wait until every expected result has come and the block has settled
  task automatic wait_for_idle();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_for_idle();
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Send one received byte, sometimes preceded by a tick or an unused opcode
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < tick_pct) send_request(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 99) < 2) send_request(OP_UNUSED, 8'($urandom));
    send_request(OP_BYTE, b);
  endtask

  // Send id, length, command, parameters and optionally the checksum
  task automatic send_frame_body(input logic [BYTE_W-1:0] len, input int n_params,
                                 input bit with_sum, input bit bad_sum);
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] sum;
    b = 8'($urandom);
    sum = b;
    send_byte(b);
    sum += len;
    send_byte(len);
    b = 8'($urandom);
    sum += b;
    send_byte(b);
    repeat (n_params) begin
      b = 8'($urandom);
      sum += b;
      send_byte(b);
    end
    if (with_sum) begin
      b = ~sum;
      if (bad_sum) b ^= 8'($urandom_range(1, 255));
      send_byte(b);
    end
  endtask

  // Arm, then send a frame of the given kind with junk around the header
  task automatic send_frame(input frame_kind_t kind, input logic [BYTE_W-1:0] len);
    logic [BYTE_W-1:0] hdr;
    int n_params;
    hdr = sb.header_reg;
    n_params = (len > 4) ? int'(len) - 3 : 1;
    send_request(OP_ARM, 8'($urandom));
    if ($urandom_range(0, 99) < 30) repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
    send_byte(hdr);
    if ($urandom_range(0, 99) < 20) send_byte(hdr ^ 8'($urandom_range(1, 255)));
    send_byte(hdr);
    case (kind)
      FRAME_GOOD:    send_frame_body(len, n_params, 1'b1, 1'b0);
      FRAME_BAD_SUM: send_frame_body(len, n_params, 1'b1, 1'b1);
      FRAME_OVERFLOW: begin
        // Twelve bytes after the command run past the store
        send_frame_body(len, 12, 1'b0, 1'b0);
        send_byte(8'($urandom));
      end
      default: send_frame_body(len, $urandom_range(0, 2), 1'b0, 1'b0);
    endcase
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic random_traffic(input int target);
    int start;
    int r;
    start = sb.requests;
    while (sb.requests - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        send_frame(FRAME_GOOD, 8'($urandom_range(0, 13)));
      end else if (r < 72) begin
        send_frame(FRAME_BAD_SUM, 8'($urandom_range(0, 13)));
      end else if (r < 80) begin
        send_frame(FRAME_OVERFLOW, 8'($urandom_range(14, 255)));
      end else if (r < 90) begin
        send_frame(FRAME_CUT, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_request(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    sb = new();
    item_ch.valid   <= 1'b0;
    item_ch.opcode  <= OP_BYTE;
    item_ch.rx_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_HEADER;
    cfg_ch.data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Requests while not armed are dropped
    send_request(OP_BYTE, HEADER_RESET);
    send_request(OP_TICK, 8'h00);
    send_request(OP_UNUSED, 8'hFF);
    // Wrong first and second header bytes, zero length byte, good checksum
    send_request(OP_ARM, 8'h00);
    send_request(OP_BYTE, 8'h00);
    send_request(OP_BYTE, HEADER_RESET);
    send_request(OP_BYTE, 8'hFF);
    send_request(OP_BYTE, HEADER_RESET);
    send_frame_body(8'h00, 1, 1'b1, 1'b0);
    // Re-arm in the middle of a header, then a short frame with a bad checksum
    send_request(OP_ARM, 8'hFF);
    send_request(OP_BYTE, HEADER_RESET);
    send_request(OP_ARM, 8'h00);
    send_request(OP_BYTE, HEADER_RESET);
    send_request(OP_BYTE, HEADER_RESET);
    send_frame_body(8'h03, 1, 1'b1, 1'b1);
    // Longest good frame, then a frame that overflows the store
    send_frame(FRAME_GOOD, 8'd13);
    send_frame(FRAME_OVERFLOW, 8'hFF);

    // Hold the result side off while long frames keep arriving back to back
    wait_for_idle();
    hold_request  = LONG_HOLD;
    sender_steady = 1'b1;
    repeat (3) send_frame(FRAME_GOOD, 8'd13);
    sender_steady = 1'b0;

    tick_pct = 5;
    random_traffic(50);

    // Header of all zeros, timeout on the first tick
    write_register(CFG_HEADER, {8'($urandom), 8'h00});
    write_register(CFG_TIMEOUT, 16'd1);
    tick_pct = 0;
    send_request(OP_ARM, 8'($urandom));
    send_request(OP_TICK, 8'($urandom));
    tick_pct = 3;
    random_traffic(35);
    write_register(CFG_TIMEOUT, 16'd0);
    send_request(OP_TICK, 8'($urandom));
    send_request(OP_ARM, 8'($urandom));
    send_request(OP_TICK, 8'($urandom));

    // Header of all ones, longest timeout; first part with no idling on either side
    write_register(CFG_HEADER, {8'($urandom), 8'hFF});
    write_register(CFG_TIMEOUT, 16'hFFFF);
    tick_pct      = 10;
    sender_steady = 1'b1;
    sink_steady   = 1'b1;
    random_traffic(20);
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    random_traffic(25);

    // Random header, short timeout so ticks end some frames early
    write_register(CFG_HEADER, 16'($urandom));
    write_register(CFG_TIMEOUT, 16'($urandom_range(8, 40)));
    tick_pct = 15;
    random_traffic(50);

    wait_for_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came", sb.pending()));
    $display("Run covered %0d requests and %0d results: %0d good frames,", sb.requests,
             sb.results, sb.good_frames);
    $display("%0d checksum errors, %0d timeouts, %0d overflows, %0d mismatches.",
             sb.csum_errors, sb.timeouts, sb.overflows, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/srfp_pkg.sv
design/srfp_item_if.sv
design/srfp_result_if.sv
design/srfp_cfg_if.sv
design/srfp_ram.sv
design/srfp_dpath.sv
design/srfp_ctrl.sv
design/servo_response_frame_parser_unit.sv
tb/servo_response_frame_parser_unit_tb.sv
